// ===== sv/lapd_rx_header_classifier_assert.svh =====
// assertion macros for the lapd receive header classifier
// defining ASSERT_OFF leaves every macro empty; no other dependencies
`ifndef LAPD_RX_HEADER_CLASSIFIER_ASSERT_SVH
`define LAPD_RX_HEADER_CLASSIFIER_ASSERT_SVH
`ifndef ASSERT_OFF
`define LRHC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lapd classifier check failed");
`define LRHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lapd classifier check failed");
`else
`define LRHC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LRHC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/lrhc_pkg.sv =====
// shared types, codes and constants of the lapd receive header classifier
// no dependencies
package lrhc_pkg;

	localparam int unsigned TEI_COUNT_DEF  = 128;
	localparam int unsigned SAPI_COUNT_DEF = 64;

	localparam logic [9:0]  MAX_INFO_RST = 10'd260;
	localparam logic        REG_MAX_INFO_LEN = 1'b0;

	localparam logic [6:0]  TEI_MGMT   = 7'd127;
	localparam logic [7:0]  TEI_ID_REQ = 8'h01;
	localparam logic [10:0] INFO_SAT   = 11'd1024;
	localparam logic [9:0]  POS_SAT    = 10'd1023;
	localparam logic [10:0] TEI_MSG_MIN = 11'd5;

	// result status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NEW_SAP  = 3'd1;
	localparam logic [2:0] ST_BAD_LEN  = 3'd2;
	localparam logic [2:0] ST_UNK_TEI  = 3'd3;
	localparam logic [2:0] ST_ACCEPT   = 3'd4;
	localparam logic [2:0] ST_IGNORED  = 3'd5;

	// frame formats
	localparam logic [1:0] FMT_I = 2'd0;
	localparam logic [1:0] FMT_S = 2'd1;
	localparam logic [1:0] FMT_U = 2'd2;

	// tei identity accept frame, last byte carries the assigned tei
	localparam logic [2:0] BEAT_LAST = 3'd7;
	localparam logic [7:0] ACCEPT_FRAME [8] = '{
		8'hFE, 8'hFF, 8'h03, 8'h0F, 8'h00, 8'h00, 8'h02, 8'h00
	};

	// frame descriptor queue
	localparam int unsigned QD     = 4;
	localparam int unsigned QPTR_W = 2;
	localparam int unsigned QCNT_W = 3;

	typedef struct packed {
		logic [2:0] status;
		logic [1:0] frame_format;
		logic [5:0] sap_id;
		logic       cmd_resp;
		logic [6:0] term_id;
		logic [6:0] send_seq;
		logic [6:0] recv_seq;
		logic       poll_final;
		logic [4:0] sup_unn_bits;
		logic [9:0] info_len;
		logic [6:0] action;
	} desc_t;

	typedef struct packed {
		logic              empty;
		logic [QCNT_W-1:0] count;
	} qstat_t;

	typedef struct packed {
		desc_t      desc;
		logic [7:0] tx_byte;
		logic       last;
	} res_t;

	// unnumbered control field is one byte, I and S are two
	function automatic logic [2:0] ctrl_len(input logic [7:0] c);
		return (c[1:0] == 2'b11) ? 3'd1 : 3'd2;
	endfunction

endpackage

// ===== sv/lrhc_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module lrhc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/lrhc_front.sv =====
// front part: byte capture, header decode and tei/sap lookup stage
// depends on lrhc_pkg and lrhc_ram
module lrhc_front #(
	parameter int unsigned TEI_COUNT  = lrhc_pkg::TEI_COUNT_DEF,
	parameter int unsigned SAPI_COUNT = lrhc_pkg::SAPI_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [7:0]          rx_byte,
	input  logic                frame_last,
	output logic                full,
	input  logic [9:0]          max_info_len,
	input  lrhc_pkg::qstat_t    qstat,
	output logic                q_push,
	output lrhc_pkg::desc_t     q_desc
);
	import lrhc_pkg::*;

	localparam int unsigned TEI_W  = $clog2(TEI_COUNT);
	localparam int unsigned SAPI_W = $clog2(SAPI_COUNT);

	typedef enum logic [2:0] {
		K_DONE   = 3'b001,
		K_ACCEPT = 3'b010,
		K_LOOKUP = 3'b100
	} kind_t;

	logic [9:0]  pos_q, pos_nx;
	logic [10:0] info_q, info_nx;
	logic        short_q, short_nx;
	logic [7:0]  hdr_q [8];
	logic [7:0]  hdr_nx [8];
	logic [7:0]  ctrl_prev;
	logic [2:0]  hl_b;
	logic        in_info;
	logic [9:0]  q_off;
	logic        acc;
	logic [QCNT_W:0] occ;

	logic [7:0]  c, d;
	logic [2:0]  hl_f;
	logic [6:0]  tei;
	desc_t       dec;
	kind_t       kind;
	logic        too_long;

	logic        s1_valid_q;
	desc_t       s1_desc_s1;
	kind_t       s1_kind_s1;
	logic        s1_long_s1;

	logic [SAPI_COUNT-1:0] rdata, row, wdata;
	logic [TEI_COUNT-1:0]  tei_pres_q;
	logic [TEI_COUNT-1:0]  row_vld_q;
	logic [TEI_W-1:0]      tei_idx, act_idx;
	logic [SAPI_W-1:0]     sapi_idx;
	logic                  tei_ok, act_ok, sapi_ok, sap_new, we;
	desc_t                 out_desc;

	// one frame may sit in the lookup stage, so count it against the queue
	assign occ  = {1'b0, qstat.count} + {{QCNT_W{1'b0}}, s1_valid_q};
	assign full = occ >= (QCNT_W+1)'(QD);
	assign acc  = push && !full;

	// per-byte capture
	always_comb begin
		short_nx  = (pos_q == '0) ? rx_byte[0] : short_q;
		ctrl_prev = short_nx ? hdr_q[1] : hdr_q[2];
		hl_b      = (short_nx ? 3'd1 : 3'd2) + ctrl_len(ctrl_prev);
		in_info   = pos_q >= {7'b0, hl_b};
		q_off     = pos_q - {7'b0, hl_b};
		for (int i = 0; i < 4; i++) begin
			hdr_nx[i] = (pos_q == 10'(i)) ? rx_byte : hdr_q[i];
		end
		// slots 4..7 keep information bytes 1..4
		for (int i = 4; i < 8; i++) begin
			hdr_nx[i] = (in_info && q_off == 10'(i - 3)) ? rx_byte : hdr_q[i];
		end
		info_nx = (in_info && info_q != INFO_SAT) ? info_q + 11'd1 : info_q;
		pos_nx  = (pos_q != POS_SAT) ? pos_q + 10'd1 : pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			info_q  <= '0;
			short_q <= 1'b0;
			hdr_q   <= '{default: '0};
		end else if (acc) begin
			pos_q   <= frame_last ? '0 : pos_nx;
			info_q  <= frame_last ? '0 : info_nx;
			short_q <= short_nx;
			hdr_q   <= hdr_nx;
		end
	end

	// header decode on the final byte
	always_comb begin
		c        = short_nx ? hdr_nx[1] : hdr_nx[2];
		d        = short_nx ? hdr_nx[2] : hdr_nx[3];
		hl_f     = (short_nx ? 3'd1 : 3'd2) + ctrl_len(c);
		tei      = short_nx ? 7'd0 : hdr_nx[1][7:1];
		too_long = info_nx > {1'b0, max_info_len};
		dec              = '0;
		dec.sap_id       = hdr_nx[0][7:2];
		dec.cmd_resp     = hdr_nx[0][1];
		dec.term_id      = tei;
		dec.info_len     = info_nx[10] ? 10'h3FF : info_nx[9:0];
		if (!c[0]) begin
			dec.frame_format = FMT_I;
			dec.send_seq     = c[7:1];
			dec.recv_seq     = d[7:1];
			dec.poll_final   = d[0];
		end else if (!c[1]) begin
			dec.frame_format = FMT_S;
			dec.sup_unn_bits = {3'b0, c[3:2]};
			dec.recv_seq     = d[7:1];
			dec.poll_final   = d[0];
		end else begin
			dec.frame_format = FMT_U;
			dec.sup_unn_bits = {c[7:5], c[3:2]};
			dec.poll_final   = c[4];
		end
		kind = K_LOOKUP;
		// frame ends inside the address or control field
		if ({7'b0, hl_f} > pos_nx) begin
			dec        = '0;
			dec.status = ST_BAD_LEN;
			kind       = K_DONE;
		end else if (tei == TEI_MGMT) begin
			kind = K_DONE;
			if (info_nx < TEI_MSG_MIN) begin
				dec.status = ST_BAD_LEN;
			end else if (hdr_nx[6] != TEI_ID_REQ) begin
				dec.status = ST_IGNORED;
			end else begin
				dec.status = ST_ACCEPT;
				dec.action = hdr_nx[7][7:1];
				kind       = K_ACCEPT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= acc && frame_last;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && frame_last) begin
			s1_desc_s1 <= dec;
			s1_kind_s1 <= kind;
			s1_long_s1 <= too_long;
		end
	end

	// sap bitmaps, one row per tei; rows never written read as empty
	lrhc_ram #(
		.WIDTH (SAPI_COUNT),
		.DEPTH (TEI_COUNT)
	) u_sap_ram (
		.clk   (clk),
		.we    (we),
		.waddr (tei_idx),
		.wdata (wdata),
		.re    (acc && frame_last),
		.raddr (tei[TEI_W-1:0]),
		.rdata (rdata)
	);

	// lookup stage
	always_comb begin
		tei_idx  = s1_desc_s1.term_id[TEI_W-1:0];
		act_idx  = s1_desc_s1.action[TEI_W-1:0];
		sapi_idx = s1_desc_s1.sap_id[SAPI_W-1:0];
		tei_ok   = {1'b0, s1_desc_s1.term_id} < 8'(TEI_COUNT);
		act_ok   = {1'b0, s1_desc_s1.action} < 8'(TEI_COUNT);
		sapi_ok  = {1'b0, s1_desc_s1.sap_id} < 7'(SAPI_COUNT);
		row      = row_vld_q[tei_idx] ? rdata : '0;
		sap_new  = sapi_ok && !row[sapi_idx];
		wdata    = row | (SAPI_COUNT'(1) << sapi_idx);
		out_desc = s1_desc_s1;
		we       = 1'b0;
		unique case (s1_kind_s1)
			K_LOOKUP: begin
				if (!(tei_ok && tei_pres_q[tei_idx])) begin
					out_desc.status = ST_UNK_TEI;
				end else begin
					we              = s1_valid_q && sap_new;
					out_desc.status = s1_long_s1 ? ST_BAD_LEN :
						(sap_new ? ST_NEW_SAP : ST_OK);
				end
			end
			K_ACCEPT, K_DONE: begin
				out_desc = s1_desc_s1;
			end
			default: begin
				out_desc = s1_desc_s1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tei_pres_q <= '0;
			row_vld_q  <= '0;
		end else begin
			if (s1_valid_q && s1_kind_s1 == K_ACCEPT && act_ok) begin
				tei_pres_q[act_idx] <= 1'b1;
			end
			if (we) begin
				row_vld_q[tei_idx] <= 1'b1;
			end
		end
	end

	assign q_push = s1_valid_q;
	assign q_desc = out_desc;

endmodule

// ===== sv/lrhc_queue.sv =====
// short descriptor queue between the front and back parts
// depends on lrhc_pkg
module lrhc_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  lrhc_pkg::desc_t  push_desc,
	input  logic             pop,
	output lrhc_pkg::desc_t  pop_desc,
	output lrhc_pkg::qstat_t stat
);
	import lrhc_pkg::*;

	desc_t             mem_q [QD];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	assign pop_desc   = mem_q[rd_ptr_q];
	assign stat.empty = (count_q == '0);
	assign stat.count = count_q;

endmodule

// ===== sv/lrhc_back.sv =====
// back part: expands frame descriptors into result beats, output register
// depends on lrhc_pkg
module lrhc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  lrhc_pkg::qstat_t qstat,
	input  lrhc_pkg::desc_t  q_desc,
	output logic             q_pop,
	input  logic             pop,
	output logic             empty,
	output lrhc_pkg::res_t   res
);
	import lrhc_pkg::*;

	desc_t      cur_q;
	logic [2:0] beat_q;
	logic       vld_q;
	logic       is_acc, last, take, done;

	always_comb begin
		is_acc = (cur_q.status == ST_ACCEPT);
		last   = !is_acc || (beat_q == BEAT_LAST);
		take   = vld_q && pop;
		done   = take && last;
		q_pop  = (!vld_q || done) && !qstat.empty;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= 1'b0;
			beat_q <= '0;
		end else if (q_pop) begin
			vld_q  <= 1'b1;
			beat_q <= '0;
		end else if (done) begin
			vld_q  <= 1'b0;
		end else if (take) begin
			beat_q <= beat_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_desc;
		end
	end

	// accept frame: fixed bytes, then the assigned tei with the ea bit
	always_comb begin
		res.desc = cur_q;
		res.last = last;
		if (!is_acc) begin
			res.tx_byte = 8'h00;
		end else if (beat_q == BEAT_LAST) begin
			res.tx_byte = {cur_q.action, 1'b1};
		end else begin
			res.tx_byte = ACCEPT_FRAME[beat_q];
		end
	end

	assign empty = !vld_q;

endmodule

// ===== sv/lapd_rx_header_classifier.sv =====
// top level of the lapd receive header classifier: config register and glue
// depends on lrhc_pkg, lrhc_front, lrhc_queue, lrhc_back and the assert header
//
// Frame bytes enter one per cycle while full is low, with frame_last on the
// final byte; only the final byte produces results, which reach the result
// ports after the header decode, the tei/sap bitmap lookup stage and the
// descriptor queue. Normal
// frames give one result beat, a tei identity request gives eight beats of
// the accept frame, and the output side can deliver one beat per cycle.
// full is raised while the four-entry descriptor queue plus the frame in
// the lookup stage leave no room, so input stalls only when the result side
// falls behind (most often during accept bursts). The sap bitmaps live in a
// ram with one valid flag per tei row, so there is no clearing pass after
// reset. max_info_len sits at byte address 0 and should be written only
// while no frame is in flight.
`include "lapd_rx_header_classifier_assert.svh"
module lapd_rx_header_classifier #(
	parameter int unsigned TEI_COUNT  = lrhc_pkg::TEI_COUNT_DEF,
	parameter int unsigned SAPI_COUNT = lrhc_pkg::SAPI_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        push,
	input  logic [7:0]  rx_byte,
	input  logic        frame_last,
	output logic        full,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  status,
	output logic [1:0]  frame_format,
	output logic [5:0]  sap_id,
	output logic        cmd_resp,
	output logic [6:0]  term_id,
	output logic [6:0]  send_seq,
	output logic [6:0]  recv_seq,
	output logic        poll_final,
	output logic [4:0]  sup_unn_bits,
	output logic [9:0]  info_len,
	output logic [7:0]  tx_byte,
	output logic        result_last
);
	import lrhc_pkg::*;

	logic [9:0] max_info_len_q;
	logic       fe_push;
	desc_t      fe_desc;
	desc_t      q_desc;
	qstat_t     qstat;
	logic       q_pop;
	res_t       res;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_info_len_q <= MAX_INFO_RST;
		end else if (psel && penable && pwrite && pready
			&& paddr[2] == REG_MAX_INFO_LEN) begin
			max_info_len_q <= pwdata[9:0];
		end
	end

	assign prdata = (paddr[2] == REG_MAX_INFO_LEN) ? {22'b0, max_info_len_q} : 32'b0;

	lrhc_front #(
		.TEI_COUNT  (TEI_COUNT),
		.SAPI_COUNT (SAPI_COUNT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.rx_byte      (rx_byte),
		.frame_last   (frame_last),
		.full         (full),
		.max_info_len (max_info_len_q),
		.qstat        (qstat),
		.q_push       (fe_push),
		.q_desc       (fe_desc)
	);

	lrhc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fe_push),
		.push_desc (fe_desc),
		.pop       (q_pop),
		.pop_desc  (q_desc),
		.stat      (qstat)
	);

	lrhc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.qstat  (qstat),
		.q_desc (q_desc),
		.q_pop  (q_pop),
		.pop    (pop),
		.empty  (empty),
		.res    (res)
	);

	assign status       = res.desc.status;
	assign frame_format = res.desc.frame_format;
	assign sap_id       = res.desc.sap_id;
	assign cmd_resp     = res.desc.cmd_resp;
	assign term_id      = res.desc.term_id;
	assign send_seq     = res.desc.send_seq;
	assign recv_seq     = res.desc.recv_seq;
	assign poll_final   = res.desc.poll_final;
	assign sup_unn_bits = res.desc.sup_unn_bits;
	assign info_len     = res.desc.info_len;
	assign tx_byte      = res.tx_byte;
	assign result_last  = res.last;

	// lookup stage never pushes into a full queue
	`LRHC_ASSERT_IMPL(a_queue_room, clk, arst_n, fe_push, qstat.count < QCNT_W'(QD))
	// only accept bursts span several beats
	`LRHC_ASSERT_IMPL(a_multi_is_accept, clk, arst_n, !empty && !result_last, status == ST_ACCEPT)
	// a burst keeps going after a beat that is not the last
	`LRHC_ASSERT_NEXT(a_burst_holds, clk, arst_n, !empty && pop && !result_last, !empty)
	// final accept beat carries the tei with the ea bit set
	`LRHC_ASSERT_IMPL(a_accept_ea, clk, arst_n, !empty && status == ST_ACCEPT && result_last, tx_byte[0])

endmodule
